### rtl/core/sdc_pkg.sv
// ----------------------------------------------------------------------------
// sdc_pkg
// Shared types and constants of the set-associative data cache.
// ----------------------------------------------------------------------------
package sdc_pkg;

    localparam int SETS       = 64;
    localparam int WAYS       = 8;
    localparam int LINE_WORDS = 8;

    localparam int ADDR_W    = 64;
    localparam int DATA_W    = 64;
    localparam int LINE_OFS  = 6;
    localparam int TAG_W     = ADDR_W - LINE_OFS;
    localparam int SET_W     = $clog2(SETS);
    localparam int WAY_W     = $clog2(WAYS);
    localparam int WORD_W    = $clog2(LINE_WORDS);
    localparam int DADDR_W   = SET_W + WAY_W + WORD_W;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 64;
    localparam int TOP_W     = 7;

    // command codes
    localparam logic [2:0] CMD_LOOKUP = 3'd0;
    localparam logic [2:0] CMD_QUERY  = 3'd1;
    localparam logic [2:0] CMD_REFILL = 3'd2;
    localparam logic [2:0] CMD_STORE  = 3'd3;
    localparam logic [2:0] CMD_READ   = 3'd4;
    localparam logic [2:0] CMD_INVAL  = 3'd5;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SKIP_MASK = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TOP_BIT   = 1'd1;

    // line states
    localparam logic [1:0] LS_INVALID = 2'd0;
    localparam logic [1:0] LS_SHARED  = 2'd1;
    localparam logic [1:0] LS_EXCL    = 2'd2;
    localparam logic [1:0] LS_MOD     = 2'd3;

    typedef struct packed {
        logic [1:0]       lstate;
        logic [TAG_W-1:0] tag;
        logic [WAY_W-1:0] rank;
        logic             dmd;
        logic             pfm;
        logic [3:0]       pft;
    } t_way;

    typedef t_way [WAYS-1:0] t_row;

    localparam int ROW_W = $bits(t_row);

    typedef struct packed {
        logic              hit;
        logic              granted;
        logic [1:0]        victim_state;
        logic [ADDR_W-1:0] victim_line_addr;
        logic [DATA_W-1:0] data_out;
        logic              error;
        logic              last;
    } t_rsp;

    // index unit status towards the control
    typedef struct packed {
        logic             busy;
        logic [SET_W-1:0] set;
    } t_idx_stat;

endpackage

### rtl/core/sdc_req_if.sv
// ----------------------------------------------------------------------------
// sdc_req_if
// Request channel of the data cache: valid/ready with the access payload.
// ----------------------------------------------------------------------------
interface sdc_req_if
    import sdc_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [2:0]        cmd;
    logic [ADDR_W-1:0] addr;
    logic              is_write;
    logic [2:0]        word_index;
    logic [DATA_W-1:0] data_in;
    logic [1:0]        new_state;
    logic              is_prefetch;
    logic [3:0]        prefetch_kind;
    logic [3:0]        byte_count;

    modport source (
        output valid, cmd, addr, is_write, word_index, data_in, new_state,
               is_prefetch, prefetch_kind, byte_count,
        input  ready
    );
    modport sink (
        input  valid, cmd, addr, is_write, word_index, data_in, new_state,
               is_prefetch, prefetch_kind, byte_count,
        output ready
    );
endinterface

### rtl/core/sdc_rsp_if.sv
// ----------------------------------------------------------------------------
// sdc_rsp_if
// Response channel of the data cache: valid/ready with the result payload.
// ----------------------------------------------------------------------------
interface sdc_rsp_if
    import sdc_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              hit;
    logic              granted;
    logic [1:0]        victim_state;
    logic [ADDR_W-1:0] victim_line_addr;
    logic [DATA_W-1:0] data_out;
    logic              error;
    logic              last;

    modport source (
        output valid, hit, granted, victim_state, victim_line_addr, data_out,
               error, last,
        input  ready
    );
    modport sink (
        input  valid, hit, granted, victim_state, victim_line_addr, data_out,
               error, last,
        output ready
    );
endinterface

### rtl/core/set_assoc_data_cache_lru.sv
// ----------------------------------------------------------------------------
// set_assoc_data_cache_lru
// Set-associative data cache with recency replacement. Way metadata of a set
// sits in one row of a metadata RAM, line words in a data RAM.
// ----------------------------------------------------------------------------
// A taken request passes the lookup, action and output states before its
// result is registered; word reads and byte stores add a data RAM state, and
// refill word 0 gives eight results, one per victim word. One request in
// flight: a new one is taken only once the sequencer is back in idle.
// Reset: all lines invalid, ranks in way order; the index select table is
// rebuilt after reset or a configuration write.
// ----------------------------------------------------------------------------
module set_assoc_data_cache_lru
    import sdc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    sdc_req_if.sink              i_req,
    sdc_rsp_if.source            o_rsp,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data
);
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_LOOK = 3'd1;
    localparam logic [2:0] ST_ACT  = 3'd2;
    localparam logic [2:0] ST_RMW  = 3'd3;
    localparam logic [2:0] ST_RD   = 3'd4;
    localparam logic [2:0] ST_EVW  = 3'd5;
    localparam logic [2:0] ST_EVO  = 3'd6;
    localparam logic [2:0] ST_OUT  = 3'd7;

    t_idx_stat idx;

    logic [2:0]        r_state, n_state;
    logic [2:0]        r_cmd;
    logic [ADDR_W-1:0] r_addr;
    logic              r_is_write;
    logic [2:0]        r_widx;
    logic [DATA_W-1:0] r_data;
    logic [1:0]        r_nstate;
    logic              r_pf;
    logic [3:0]        r_pkind;
    logic [3:0]        r_bcnt;
    logic [SET_W-1:0]  r_set;
    t_row              r_row;
    logic              r_hit;
    logic [WAY_W-1:0]  r_hway;
    logic [WAY_W-1:0]  r_vway;
    logic [WORD_W-1:0] r_k, n_k;
    logic [SETS-1:0]   r_st_valid;
    logic [SETS-1:0]   r_rk_valid;
    t_rsp              r_res, n_res;
    t_rsp              r_out;
    logic              r_ov;

    logic              accept;
    logic              slot_free;
    logic              load_out;
    logic              mark_row;
    logic              inval_all;

    logic              meta_we;
    t_row              meta_wdata;
    logic [ROW_W-1:0]  meta_rdata;
    logic              data_we;
    logic [DADDR_W-1:0] data_waddr;
    logic [DATA_W-1:0] data_wdata;
    logic              data_re;
    logic [DADDR_W-1:0] data_raddr;
    logic [DATA_W-1:0] data_rdata;

    t_row              look_row;
    logic [WAYS-1:0]   match;
    logic              look_hit;
    logic [WAY_W-1:0]  look_hway;
    logic [WAY_W-1:0]  look_vway;
    logic [2:0]        off;
    logic [4:0]        end_byte;
    logic [DATA_W-1:0] merged;
    logic [WORD_W-1:0] word_sel;

    // move a way to the front of the recency order
    function automatic t_row make_mru(input t_row row, input logic [WAY_W-1:0] way);
        t_row             res;
        logic [WAY_W-1:0] old;
        res = row;
        old = row[way].rank;
        for (int o = 0; o < WAYS; o++) begin
            if (WAY_W'(o) != way && row[o].rank < old) begin
                res[o].rank = row[o].rank + WAY_W'(1);
            end
        end
        res[way].rank = '0;
        return res;
    endfunction

    sdc_index u_index (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_addr     (i_req.addr),
        .o_stat     (idx)
    );

    sdc_ram #(.W(ROW_W), .D(SETS)) u_meta (
        .i_clk   (i_clk),
        .i_we    (meta_we),
        .i_waddr (r_set),
        .i_wdata (meta_wdata),
        .i_re    (accept),
        .i_raddr (idx.set),
        .o_rdata (meta_rdata)
    );

    sdc_ram #(.W(DATA_W), .D(SETS * WAYS * LINE_WORDS)) u_data (
        .i_clk   (i_clk),
        .i_we    (data_we),
        .i_waddr (data_waddr),
        .i_wdata (data_wdata),
        .i_re    (data_re),
        .i_raddr (data_raddr),
        .o_rdata (data_rdata)
    );

    assign i_req.ready = (r_state == ST_IDLE) && !idx.busy;
    assign accept      = i_req.valid && i_req.ready;
    assign slot_free   = !r_ov || o_rsp.ready;
    assign off         = r_addr[2:0];
    assign word_sel    = r_addr[LINE_OFS-1:3];
    assign end_byte    = 5'(off) + 5'(r_bcnt);

    // row as seen after reset and invalidate-all
    always_comb begin
        look_row = t_row'(meta_rdata);
        for (int w = 0; w < WAYS; w++) begin
            if (!r_rk_valid[r_set]) begin
                look_row[w].rank = WAY_W'(w);
                look_row[w].dmd  = 1'b0;
                look_row[w].pfm  = 1'b0;
                look_row[w].pft  = '0;
            end
            if (!r_st_valid[r_set] || !r_rk_valid[r_set]) begin
                look_row[w].lstate = LS_INVALID;
            end
        end
    end

    // tag match, most recent hit and victim way
    always_comb begin
        logic [WAYS-1:0] best;
        for (int w = 0; w < WAYS; w++) begin
            match[w] = (look_row[w].lstate != LS_INVALID) &&
                       (look_row[w].tag == r_addr[ADDR_W-1:LINE_OFS]);
        end
        for (int w = 0; w < WAYS; w++) begin
            best[w] = match[w];
            for (int v = 0; v < WAYS; v++) begin
                if (v != w && match[v] && look_row[v].rank < look_row[w].rank) begin
                    best[w] = 1'b0;
                end
            end
        end
        look_hit  = |match;
        look_hway = '0;
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (best[w]) begin
                look_hway = WAY_W'(w);
            end
        end
        look_vway = '0;
        for (int w = 0; w < WAYS; w++) begin
            if (look_row[w].rank == WAY_W'(WAYS - 1)) begin
                look_vway = WAY_W'(w);
            end
        end
    end

    // byte store merge
    always_comb begin
        for (int b = 0; b < 8; b++) begin
            if (5'(b) >= 5'(off) && 5'(b) < end_byte) begin
                merged[b*8 +: 8] = r_data[(b - 32'(off))*8 +: 8];
            end else begin
                merged[b*8 +: 8] = data_rdata[b*8 +: 8];
            end
        end
    end

    // control sequencer
    always_comb begin
        t_row row_tmp;
        n_state    = r_state;
        n_k        = r_k;
        n_res      = r_res;
        meta_we    = 1'b0;
        meta_wdata = r_row;
        data_we    = 1'b0;
        data_waddr = {r_set, r_hway, r_widx};
        data_wdata = r_data;
        data_re    = 1'b0;
        data_raddr = {r_set, r_hway, word_sel};
        load_out   = 1'b0;
        mark_row   = 1'b0;
        inval_all  = 1'b0;
        row_tmp    = r_row;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = ST_LOOK;
                end
            end
            ST_LOOK: begin
                n_state = ST_ACT;
            end
            ST_ACT: begin
                n_res      = '0;
                n_res.last = 1'b1;
                n_res.hit  = r_hit;
                n_state    = ST_OUT;
                case (r_cmd)
                    CMD_LOOKUP: begin
                        if (r_hit && (!r_is_write || r_row[r_hway].lstate == LS_EXCL ||
                                      r_row[r_hway].lstate == LS_MOD)) begin
                            n_res.granted = 1'b1;
                            row_tmp[r_hway].dmd = 1'b1;
                            meta_wdata = make_mru(row_tmp, r_hway);
                            meta_we    = 1'b1;
                            mark_row   = 1'b1;
                        end
                    end
                    CMD_QUERY: begin
                        n_res.hit = r_hit;
                    end
                    CMD_REFILL: begin
                        if (r_widx == '0) begin
                            row_tmp[r_vway].lstate = r_nstate;
                            row_tmp[r_vway].tag    = r_addr[ADDR_W-1:LINE_OFS];
                            row_tmp[r_vway].pfm    = r_pf;
                            row_tmp[r_vway].dmd    = !r_pf;
                            row_tmp[r_vway].pft    = r_pf ? r_pkind : 4'd0;
                            meta_wdata = make_mru(row_tmp, r_vway);
                            meta_we    = 1'b1;
                            mark_row   = 1'b1;
                            n_k        = '0;
                            data_re    = 1'b1;
                            data_raddr = {r_set, r_vway, WORD_W'(0)};
                            n_state    = ST_EVW;
                        end else if (r_hit) begin
                            data_we = 1'b1;
                        end else begin
                            n_res.error = 1'b1;
                        end
                    end
                    CMD_STORE: begin
                        if (!r_hit || end_byte > 5'd8) begin
                            n_res.error = 1'b1;
                        end else begin
                            data_re = 1'b1;
                            n_state = ST_RMW;
                        end
                    end
                    CMD_READ: begin
                        if (!r_hit) begin
                            n_res.error = 1'b1;
                        end else begin
                            data_re = 1'b1;
                            n_state = ST_RD;
                        end
                    end
                    CMD_INVAL: begin
                        n_res.hit = 1'b0;
                        inval_all = 1'b1;
                    end
                    default: begin
                        n_res.hit = 1'b0;
                    end
                endcase
            end
            ST_RMW: begin
                data_we    = 1'b1;
                data_waddr = {r_set, r_hway, word_sel};
                data_wdata = merged;
                row_tmp[r_hway].lstate = LS_MOD;
                meta_wdata = row_tmp;
                meta_we    = 1'b1;
                mark_row   = 1'b1;
                n_state    = ST_OUT;
            end
            ST_RD: begin
                n_res.data_out = data_rdata;
                n_state        = ST_OUT;
            end
            ST_EVW: begin
                // victim fields come from the row read before the install
                n_res = '0;
                n_res.victim_state = r_row[r_vway].lstate;
                if (r_row[r_vway].lstate != LS_INVALID) begin
                    n_res.victim_line_addr = {r_row[r_vway].tag, LINE_OFS'(0)};
                    n_res.data_out         = data_rdata;
                end
                n_res.last = (r_k == WORD_W'(LINE_WORDS - 1));
                n_state    = ST_EVO;
            end
            ST_EVO: begin
                if (slot_free) begin
                    load_out = 1'b1;
                    if (r_res.last) begin
                        data_we    = 1'b1;
                        data_waddr = {r_set, r_vway, WORD_W'(0)};
                        n_state    = ST_IDLE;
                    end else begin
                        n_k        = r_k + WORD_W'(1);
                        data_re    = 1'b1;
                        data_raddr = {r_set, r_vway, n_k};
                        n_state    = ST_EVW;
                    end
                end
            end
            ST_OUT: begin
                if (slot_free) begin
                    load_out = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control state, row valid bits and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_st_valid <= '0;
            r_rk_valid <= '0;
            r_ov       <= 1'b0;
        end else begin
            r_state <= n_state;
            if (inval_all) begin
                r_st_valid <= '0;
            end else if (mark_row) begin
                r_st_valid[r_set] <= 1'b1;
            end
            if (mark_row) begin
                r_rk_valid[r_set] <= 1'b1;
            end
            if (load_out) begin
                r_ov <= 1'b1;
            end else if (o_rsp.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // request fields, lookup results and result staging
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd      <= i_req.cmd;
            r_addr     <= i_req.addr;
            r_is_write <= i_req.is_write;
            r_widx     <= i_req.word_index;
            r_data     <= i_req.data_in;
            r_nstate   <= i_req.new_state;
            r_pf       <= i_req.is_prefetch;
            r_pkind    <= i_req.prefetch_kind;
            r_bcnt     <= i_req.byte_count;
            r_set      <= idx.set;
        end
        if (r_state == ST_LOOK) begin
            r_row  <= look_row;
            r_hit  <= look_hit;
            r_hway <= look_hway;
            r_vway <= look_vway;
        end
        r_k   <= n_k;
        r_res <= n_res;
        if (load_out) begin
            r_out <= r_res;
        end
    end

    assign o_rsp.valid            = r_ov;
    assign o_rsp.hit              = r_out.hit;
    assign o_rsp.granted          = r_out.granted;
    assign o_rsp.victim_state     = r_out.victim_state;
    assign o_rsp.victim_line_addr = r_out.victim_line_addr;
    assign o_rsp.data_out         = r_out.data_out;
    assign o_rsp.error            = r_out.error;
    assign o_rsp.last             = r_out.last;

    // only refill word 0 gives results that are not the last of a request
    a_multi_only_refill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && !o_rsp.last |-> r_cmd == CMD_REFILL)
        else $error("non-final result outside a refill");

    // a grant is always a hit
    a_grant_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && o_rsp.granted |-> o_rsp.hit && !o_rsp.error)
        else $error("grant without hit");

    // requests are taken only when the sequencer is idle
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.ready |-> r_state == ST_IDLE && !idx.busy)
        else $error("ready outside idle");

    // a result is never loaded over one that has not been taken
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_out |-> !r_ov || o_rsp.ready)
        else $error("result overwritten");
endmodule

### rtl/core/sdc_ram.sv
// ----------------------------------------------------------------------------
// sdc_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module sdc_ram #(
    parameter int W = 8,
    parameter int D = 16
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic                 i_re,
    input  logic [$clog2(D)-1:0] i_raddr,
    output logic [W-1:0]         o_rdata
);
    logic [W-1:0] mem [D];
    logic [W-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

### rtl/core/sdc_index.sv
// ----------------------------------------------------------------------------
// sdc_index
// Configuration registers and set index gathering. After reset or a
// configuration write the address bits are scanned one per cycle to build
// the bit select table; the index is then a plain mux of address bits.
// ----------------------------------------------------------------------------
module sdc_index
    import sdc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic [ADDR_W-1:0]    i_addr,
    output t_idx_stat            o_stat
);
    localparam int GOT_W  = $clog2(SET_W + 1);
    localparam int GSEL_W = (SET_W > 1) ? $clog2(SET_W) : 1;

    logic [CFG_W-1:0] r_skip;
    logic [TOP_W-1:0] r_top;
    logic             r_busy;
    logic [TOP_W-1:0] r_scan_p;
    logic [GOT_W-1:0] r_got;
    logic [5:0]       r_sel  [SET_W];
    logic [SET_W-1:0] r_selv;

    logic [TOP_W-1:0] top_eff;
    logic             scan_end;
    logic [SET_W-1:0] raw;

    // top bit above the address width acts as the address width
    assign top_eff  = (r_top > TOP_W'(ADDR_W)) ? TOP_W'(ADDR_W) : r_top;
    assign scan_end = (r_scan_p >= top_eff) || (r_got == GOT_W'(SET_W));

    // configuration and select table scan
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skip   <= '0;
            r_top    <= TOP_W'(ADDR_W);
            r_busy   <= 1'b1;
            r_scan_p <= TOP_W'(LINE_OFS);
            r_got    <= '0;
            r_selv   <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SKIP_MASK: r_skip <= i_cfg_data;
                CFG_TOP_BIT:   r_top  <= i_cfg_data[TOP_W-1:0];
                default:       r_skip <= r_skip;
            endcase
            r_busy   <= 1'b1;
            r_scan_p <= TOP_W'(LINE_OFS);
            r_got    <= '0;
            r_selv   <= '0;
        end else if (r_busy) begin
            if (scan_end) begin
                r_busy <= 1'b0;
            end else begin
                if (!r_skip[r_scan_p[5:0]]) begin
                    r_selv[r_got[GSEL_W-1:0]] <= 1'b1;
                    r_got <= r_got + GOT_W'(1);
                end
                r_scan_p <= r_scan_p + TOP_W'(1);
            end
        end
    end

    // select table payload
    always_ff @(posedge i_clk) begin
        if (r_busy && !scan_end && !r_skip[r_scan_p[5:0]]) begin
            r_sel[r_got[GSEL_W-1:0]] <= r_scan_p[5:0];
        end
    end

    // gather index bits
    always_comb begin
        for (int j = 0; j < SET_W; j++) begin
            raw[j] = r_selv[j] & i_addr[r_sel[j]];
        end
    end

    // wrap into the set range
    assign o_stat.set  = ({1'b0, raw} >= (SET_W + 1)'(SETS)) ? raw - SET_W'(SETS) : raw;
    assign o_stat.busy = r_busy;
endmodule

### sim/set_assoc_data_cache_lru_tb.sv
// ----------------------------------------------------------------------------
// set_assoc_data_cache_lru_tb
// Self-checking bench for the data cache. A line-state model predicts every
// result transfer and checks it field by field. Stimulus is a short directed
// part, then complete refill bursts mixed with lookups, queries, stores, word
// reads and invalidations. Index settings are changed between phases and
// both channels idle at random.
// ----------------------------------------------------------------------------
module set_assoc_data_cache_lru_tb;
    import sdc_pkg::*;

    localparam int HOLD_CYCLES  = 300;
    localparam int STALL_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 20;
    localparam int PHASES       = 5;
    localparam int PHASE_ITEMS  = 36;
    localparam int POOL_LINES   = 24;

    typedef struct {
        logic [2:0]        cmd;
        logic [ADDR_W-1:0] addr;
        logic              is_write;
        logic [2:0]        word_index;
        logic [DATA_W-1:0] data_in;
        logic [1:0]        new_state;
        logic              is_prefetch;
        logic [3:0]        prefetch_kind;
        logic [3:0]        byte_count;
    } t_access;

    // line-state model and the results it still waits for
    class cache_scoreboard;
        logic [1:0]        lstate [SETS*WAYS];
        logic [TAG_W-1:0]  ltag   [SETS*WAYS];
        logic [DATA_W-1:0] lword  [SETS*WAYS*LINE_WORDS];
        int                lrank  [SETS*WAYS];
        logic [63:0]       skip_mask;
        int                top_bit;
        t_rsp              pending_rsp [$];
        int                mismatches;

        function new();
            skip_mask  = '0;
            top_bit    = 64;
            mismatches = 0;
            for (int i = 0; i < SETS*WAYS; i++) begin
                lstate[i] = LS_INVALID;
                ltag[i]   = '0;
                lrank[i]  = i % WAYS;
            end
            foreach (lword[i]) lword[i] = '0;
        endfunction

        function int set_of(logic [ADDR_W-1:0] addr);
            int got;
            int idx;
            int top;
            got = 0;
            idx = 0;
            top = (top_bit > 64) ? 64 : top_bit;
            for (int p = LINE_OFS; p < top && got < SET_W; p++) begin
                if (!skip_mask[p]) begin
                    idx = idx | (int'(addr[p]) << got);
                    got++;
                end
            end
            return idx % SETS;
        endfunction

        function int find_line(int set, logic [TAG_W-1:0] tag);
            int hit_line;
            int hit_rank;
            hit_line = -1;
            hit_rank = WAYS;
            for (int w = 0; w < WAYS; w++) begin
                if (lstate[set*WAYS+w] != LS_INVALID && ltag[set*WAYS+w] == tag
                    && lrank[set*WAYS+w] < hit_rank) begin
                    hit_rank = lrank[set*WAYS+w];
                    hit_line = set*WAYS + w;
                end
            end
            return hit_line;
        endfunction

        function void promote(int set, int ln);
            for (int w = 0; w < WAYS; w++)
                if (set*WAYS+w != ln && lrank[set*WAYS+w] < lrank[ln])
                    lrank[set*WAYS+w]++;
            lrank[ln] = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
            if (idx == CFG_SKIP_MASK) skip_mask = val;
            else top_bit = int'(val[TOP_W-1:0]);
        endfunction

        // accepted request: update the model and queue its results
        function void note_access(t_access a);
            int set;
            int ln;
            int victim;
            int ofs;
            logic [TAG_W-1:0] tag;
            logic [2:0] wsel;
            logic [DATA_W-1:0] v;
            t_rsp r;
            set  = set_of(a.addr);
            tag  = a.addr[ADDR_W-1:LINE_OFS];
            wsel = a.addr[5:3];
            ln   = find_line(set, tag);
            r    = '0;
            r.last = 1'b1;
            if (a.cmd == CMD_REFILL && a.word_index == 0) begin
                victim = set*WAYS;
                for (int w = 0; w < WAYS; w++)
                    if (lrank[set*WAYS+w] == WAYS-1) victim = set*WAYS + w;
                for (int k = 0; k < LINE_WORDS; k++) begin
                    r = '0;
                    r.victim_state = lstate[victim];
                    if (lstate[victim] != LS_INVALID) begin
                        r.victim_line_addr = {ltag[victim], 6'b0};
                        r.data_out         = lword[victim*LINE_WORDS+k];
                    end
                    r.last = (k == LINE_WORDS-1);
                    pending_rsp = {pending_rsp, r};
                end
                lstate[victim] = a.new_state;
                ltag[victim]   = tag;
                lword[victim*LINE_WORDS] = a.data_in;
                for (int k = 1; k < LINE_WORDS; k++) lword[victim*LINE_WORDS+k] = '0;
                promote(set, victim);
                return;
            end
            r.hit = (ln >= 0);
            case (a.cmd)
                CMD_LOOKUP: begin
                    if (ln >= 0 && (!a.is_write || lstate[ln] == LS_EXCL
                                    || lstate[ln] == LS_MOD)) begin
                        r.granted = 1'b1;
                        promote(set, ln);
                    end
                end
                CMD_QUERY: ;
                CMD_REFILL: begin
                    if (ln < 0) r.error = 1'b1;
                    else lword[ln*LINE_WORDS+a.word_index] = a.data_in;
                end
                CMD_STORE: begin
                    ofs = int'(a.addr[2:0]);
                    if (ln < 0 || ofs + int'(a.byte_count) > 8) begin
                        r.error = 1'b1;
                    end else begin
                        v = lword[ln*LINE_WORDS+wsel];
                        for (int k = 0; k < a.byte_count; k++)
                            v[(ofs+k)*8 +: 8] = a.data_in[k*8 +: 8];
                        lword[ln*LINE_WORDS+wsel] = v;
                        lstate[ln] = LS_MOD;
                    end
                end
                CMD_READ: begin
                    if (ln < 0) r.error = 1'b1;
                    else r.data_out = lword[ln*LINE_WORDS+wsel];
                end
                CMD_INVAL: begin
                    foreach (lstate[i]) lstate[i] = LS_INVALID;
                    r.hit = 1'b0;
                end
                default: r.hit = 1'b0;
            endcase
            pending_rsp = {pending_rsp, r};
        endfunction

        function void report_mismatch(string what, logic [63:0] got, logic [63:0] want);
            $display("[%0t] mismatch on %s: got %h, expected %h", $time, what, got, want);
            mismatches++;
        endfunction

        // result transfer: compare with the oldest expectation
        function void check_result(t_rsp got);
            t_rsp want;
            if (pending_rsp.size() == 0) begin
                report_mismatch("unexpected result", 64'(got.last), 64'(0));
                return;
            end
            want = pending_rsp.pop_front();
            if (got.hit !== want.hit) report_mismatch("hit", 64'(got.hit), 64'(want.hit));
            if (got.granted !== want.granted)
                report_mismatch("granted", 64'(got.granted), 64'(want.granted));
            if (got.victim_state !== want.victim_state)
                report_mismatch("victim_state", 64'(got.victim_state),
                                64'(want.victim_state));
            if (got.victim_line_addr !== want.victim_line_addr)
                report_mismatch("victim_line_addr", got.victim_line_addr,
                                want.victim_line_addr);
            if (got.data_out !== want.data_out)
                report_mismatch("data_out", got.data_out, want.data_out);
            if (got.error !== want.error)
                report_mismatch("error", 64'(got.error), 64'(want.error));
            if (got.last !== want.last) report_mismatch("last", 64'(got.last), 64'(want.last));
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [CFG_W-1:0]     cfg_data;

    sdc_req_if req_if ();
    sdc_rsp_if rsp_if ();

    set_assoc_data_cache_lru u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req_if.sink),
        .o_rsp      (rsp_if.source),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    cache_scoreboard   sb;
    bit                idle_on;
    bit                hold_req;
    int                stall_cnt;
    logic [ADDR_W-1:0] line_pool [POOL_LINES];

    // clock
    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    // transfer monitor on both channels
    always @(posedge i_clk) begin
        t_access a;
        t_rsp    r;
        if (i_rst_n) begin
            if (req_if.valid && req_if.ready) begin
                a.cmd           = req_if.cmd;
                a.addr          = req_if.addr;
                a.is_write      = req_if.is_write;
                a.word_index    = req_if.word_index;
                a.data_in       = req_if.data_in;
                a.new_state     = req_if.new_state;
                a.is_prefetch   = req_if.is_prefetch;
                a.prefetch_kind = req_if.prefetch_kind;
                a.byte_count    = req_if.byte_count;
                sb.note_access(a);
            end
            if (rsp_if.valid && rsp_if.ready) begin
                r.hit              = rsp_if.hit;
                r.granted          = rsp_if.granted;
                r.victim_state     = rsp_if.victim_state;
                r.victim_line_addr = rsp_if.victim_line_addr;
                r.data_out         = rsp_if.data_out;
                r.error            = rsp_if.error;
                r.last             = rsp_if.last;
                sb.check_result(r);
            end
        end
    end

    // watchdog on cycles with no transfer
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
                stall_cnt = 0;
            else
                stall_cnt++;
            if (stall_cnt >= STALL_LIMIT) begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // result side readiness, with random stalls and one long hold-off
    initial begin
        rsp_if.ready = 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_req) begin
                rsp_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                rsp_if.ready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge i_clk);
            end else begin
                rsp_if.ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic t_access rand_access();
        t_access a;
        a.cmd           = 3'($urandom_range(0, 5));
        a.addr          = rand64();
        a.is_write      = 1'($urandom);
        a.word_index    = 3'($urandom_range(1, 7));
        a.data_in       = rand64();
        a.new_state     = 2'($urandom_range(1, 3));
        a.is_prefetch   = 1'($urandom);
        a.prefetch_kind = 4'($urandom);
        a.byte_count    = 4'($urandom_range(1, 8));
        return a;
    endfunction

    // offer one request and hold it until it is taken
    task automatic send(t_access a);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
        req_if.valid         <= 1'b1;
        req_if.cmd           <= a.cmd;
        req_if.addr          <= a.addr;
        req_if.is_write      <= a.is_write;
        req_if.word_index    <= a.word_index;
        req_if.data_in       <= a.data_in;
        req_if.new_state     <= a.new_state;
        req_if.is_prefetch   <= a.is_prefetch;
        req_if.prefetch_kind <= a.prefetch_kind;
        req_if.byte_count    <= a.byte_count;
        do @(posedge i_clk); while (!req_if.ready);
    endtask

    // a whole line: word 0 installs it, words 1..7 fill the rest
    task automatic refill_line(logic [ADDR_W-1:0] line, logic [DATA_W-1:0] word0,
                               ref int count);
        t_access a;
        a = rand_access();
        a.cmd        = CMD_REFILL;
        a.addr       = line | ADDR_W'($urandom_range(0, 63));
        a.word_index = 3'd0;
        a.data_in    = word0;
        send(a);
        for (int k = 1; k < LINE_WORDS; k++) begin
            a.word_index = 3'(k);
            a.data_in    = rand64();
            send(a);
        end
        count += LINE_WORDS;
    endtask

    task automatic wait_drained();
        req_if.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending_rsp.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge i_clk);
        cfg_we   <= 1'b0;
        sb.write_reg(idx, val);
    endtask

    function automatic logic [ADDR_W-1:0] pool_addr();
        return line_pool[$urandom_range(0, POOL_LINES-1)] | ADDR_W'($urandom_range(0, 63));
    endfunction

    task automatic directed_part();
        t_access a;
        int n;
        n = 0;
        refill_line({{58{1'b1}}, 6'b0}, '1, n);
        refill_line('0, '0, n);
        a = rand_access();
        a.addr = '1;
        a.cmd = CMD_LOOKUP; a.is_write = 1'b0; send(a);
        a.is_write = 1'b1; send(a);
        a.cmd = CMD_QUERY; send(a);
        // full-word store, then a store that runs past the word
        a.cmd = CMD_STORE; a.addr = {{58{1'b1}}, 6'b111000}; a.byte_count = 4'd8; send(a);
        a.addr = '1; a.byte_count = 4'd2; send(a);
        a.cmd = CMD_READ; a.addr = {{58{1'b1}}, 6'b111000}; send(a);
        a.cmd = CMD_LOOKUP; a.is_write = 1'b1; send(a);
        // misses on read, store and a later refill word
        a.addr = 64'h40; a.cmd = CMD_READ; send(a);
        a.cmd = CMD_STORE; a.byte_count = 4'd1; send(a);
        a.cmd = CMD_REFILL; a.word_index = 3'd7; send(a);
        a.cmd = CMD_INVAL; send(a);
        a.cmd = CMD_LOOKUP; a.addr = '0; a.is_write = 1'b0; send(a);
    endtask

    task automatic random_part(int target);
        t_access a;
        int n;
        int pick;
        n = 0;
        while (n < target) begin
            a = rand_access();
            pick = $urandom_range(0, 99);
            if (pick < 30) begin
                refill_line(pool_addr() & ~ADDR_W'(63), rand64(), n);
            end else begin
                if (pick < 88) a.addr = pool_addr();
                if (pick < 45) a.cmd = CMD_LOOKUP;
                else if (pick < 52) a.cmd = CMD_QUERY;
                else if (pick < 68) a.cmd = CMD_STORE;
                else if (pick < 84) a.cmd = CMD_READ;
                else if (pick < 88) a.cmd = CMD_REFILL;
                else if (pick < 90) a.cmd = CMD_INVAL;
                send(a);
                n++;
            end
        end
    endtask

    initial begin
        logic [CFG_W-1:0] masks [PHASES];
        int               tops  [PHASES];
        logic [ADDR_W-1:0] base;
        sb        = new();
        idle_on   = 1'b1;
        hold_req  = 1'b0;
        stall_cnt = 0;
        i_rst_n   = 1'b0;
        cfg_we    = 1'b0;
        cfg_idx   = CFG_SKIP_MASK;
        cfg_data  = '0;
        req_if.valid         = 1'b0;
        req_if.cmd           = CMD_LOOKUP;
        req_if.addr          = '0;
        req_if.is_write      = 1'b0;
        req_if.word_index    = '0;
        req_if.data_in       = '0;
        req_if.new_state     = LS_SHARED;
        req_if.is_prefetch   = 1'b0;
        req_if.prefetch_kind = '0;
        req_if.byte_count    = 4'd1;
        masks = '{64'h0, (rand64() & 64'hffff_ffff_ffff_f000) | 64'h2a0, '1, 64'h0,
                  rand64()};
        tops  = '{64, 64, 64, 7, $urandom_range(7, 64)};

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        directed_part();
        for (int ph = 0; ph < PHASES; ph++) begin
            wait_drained();
            write_cfg(CFG_SKIP_MASK, masks[ph]);
            write_cfg(CFG_TOP_BIT, CFG_W'(tops[ph]));
            // lines that differ only in bits 6 to 8 and 60 to 63, so many of them share a set
            base = rand64();
            foreach (line_pool[i])
                line_pool[i] = ((base ^ (rand64() & 64'hf000_0000_0000_01c0))
                                & ~ADDR_W'(63));
            if (ph == 1) hold_req = 1'b1;
            if (ph == PHASES-1) idle_on = 1'b0;
            random_part(PHASE_ITEMS);
        end
        wait_drained();

        if (sb.mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

### sim.f
rtl/core/sdc_pkg.sv
rtl/core/sdc_req_if.sv
rtl/core/sdc_rsp_if.sv
rtl/core/sdc_ram.sv
rtl/core/sdc_index.sv
rtl/core/set_assoc_data_cache_lru.sv
sim/set_assoc_data_cache_lru_tb.sv
